### hw/rtl/rgbd_pyramid_level_downsampler_defines.svh
// Assertion macros for the RGB-D pyramid level downsampler.
// No dependencies; included by the modules that carry assertions.
`ifndef RGBD_PYRAMID_LEVEL_DOWNSAMPLER_DEFINES_SVH
`define RGBD_PYRAMID_LEVEL_DOWNSAMPLER_DEFINES_SVH

// Check that an implication holds at every clock edge outside reset.
`define RPLD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define RPLD_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/rpld_pkg.sv
// Package for the RGB-D pyramid level downsampler: sizes, register codes,
// row store entry type and the rounding helper. No dependencies.
`timescale 1ns / 1ps

package rpld_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 4096;
  localparam int StoreDepth = MaxWidth / 2;

  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int SlotW      = $clog2(StoreDepth);
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 13;

  localparam int ChanW  = 8;
  localparam int PairW  = ChanW + 1;
  localparam int QuadW  = ChanW + 2;
  localparam int DepthW = 16;
  localparam int TdataW = 40;

  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // Register index, taken from paddr[2]
  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  localparam logic [WidthRegW-1:0]  WidthReset  = WidthRegW'(640);
  localparam logic [HeightRegW-1:0] HeightReset = HeightRegW'(480);

  // One entry of the upper row store: pair sums of the even row, left depth
  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic [PairW-1:0]  blue;
    logic [PairW-1:0]  green;
    logic [PairW-1:0]  red;
  } row_entry_t;

  typedef struct packed {
    logic [PairW-1:0] blue;
    logic [PairW-1:0] green;
    logic [PairW-1:0] red;
  } pair_sum_t;

  // Sum of four samples divided by four, ties to even
  function automatic logic [ChanW-1:0] mean4(input logic [QuadW-1:0] s);
    logic [ChanW-1:0] q;
    logic             up;
    q  = s[QuadW-1:2];
    up = (s[1:0] == 2'b11) || ((s[1:0] == 2'b10) && q[0]);
    return q + ChanW'(up);
  endfunction

endpackage

### hw/rtl/rgbd_pyramid_level_downsampler.sv
// Top level of the RGB-D pyramid level downsampler: 2x2 box mean of colour,
// top-left depth subsample. Depends on rpld_pkg and the defines header.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid/tready   | tdata: red, green, blue, depth
//  m_axis    | out       | m_axis_tvalid/tready   | tdata as input, tlast: frame end
//  apb       | in        | psel/penable, pready=1 | image_width @0, image_height @4
//
// One pixel is taken every cycle unless a downstream stall holds input off; the
// row store sees one read or write per pixel pair, never both. The result for an
// odd-row, odd-column pixel passes the store read stage, then the rounding stage.
// Reset clears counters, valid flags and size registers; the left-pixel registers are unreset payload.
// Downstream stall first fills the result register, then the read stage; only
// then is input request held off. No clearing pass: the store is always
// written on the even row before the odd row reads it.
`timescale 1ns / 1ps

`include "rgbd_pyramid_level_downsampler_defines.svh"

module rgbd_pyramid_level_downsampler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] in_red, [15:8] in_green, [23:16] in_blue, [39:24] in_depth
  input  logic [rpld_pkg::TdataW-1:0]   s_axis_tdata,
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [39:24] out_depth
  output logic [rpld_pkg::TdataW-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpld_pkg::ApbAddrW-1:0] paddr,
  input  logic [rpld_pkg::ApbDataW-1:0] pwdata,
  output logic [rpld_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  import rpld_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegImageWidth) begin
        width_q <= pwdata[WidthRegW-1:0];
      end else begin
        height_q <= pwdata[HeightRegW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegImageWidth) begin
      prdata = ApbDataW'(width_q);
    end else begin
      prdata = ApbDataW'(height_q);
    end
  end

  // Clamp to the supported frame size
  logic [ColW:0] eff_w;
  logic [RowW:0] eff_h;

  always_comb begin
    if (width_q < WidthRegW'(2)) begin
      eff_w = (ColW+1)'(2);
    end else if (width_q > WidthRegW'(MaxWidth)) begin
      eff_w = (ColW+1)'(MaxWidth);
    end else begin
      eff_w = (ColW+1)'(width_q);
    end
    if (height_q < HeightRegW'(2)) begin
      eff_h = (RowW+1)'(2);
    end else if (height_q > HeightRegW'(MaxHeight)) begin
      eff_h = (RowW+1)'(MaxHeight);
    end else begin
      eff_h = (RowW+1)'(height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline advance
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic s1_valid_q;
  logic out_adv;
  logic s1_adv;
  logic s_accept;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s1_adv        = !s1_valid_q || out_adv;
  assign s_axis_tready = s1_adv;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  // ---------------------------------------------------------------------------
  // Position counters
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            row_end;
  logic            frame_end_hit;

  assign row_end = ((ColW+1)'(col_q) == eff_w - (ColW+1)'(1));

  // Final result sits on the last even-aligned odd column of the last odd row
  assign frame_end_hit =
    ((ColW+1)'(col_q) == {eff_w[ColW:1], 1'b0} - (ColW+1)'(1)) &&
    ((RowW+1)'(row_q) == {eff_h[RowW:1], 1'b0} - (RowW+1)'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (s_accept) begin
      if (row_end) begin
        col_d = '0;
        if ((RowW+1)'(row_q) == eff_h - (RowW+1)'(1)) begin
          row_d = '0;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input unpack and left pixel
  // ---------------------------------------------------------------------------
  logic [ChanW-1:0]  in_red, in_green, in_blue;
  logic [DepthW-1:0] in_depth;
  logic [ChanW-1:0]  left_red_q, left_green_q, left_blue_q;
  logic [DepthW-1:0] left_depth_q;

  assign in_red   = s_axis_tdata[7:0];
  assign in_green = s_axis_tdata[15:8];
  assign in_blue  = s_axis_tdata[23:16];
  assign in_depth = s_axis_tdata[39:24];

  // Hold the even-column pixel until its right neighbor arrives
  always_ff @(posedge clk_i) begin
    if (s_accept && !col_q[0]) begin
      left_red_q   <= in_red;
      left_green_q <= in_green;
      left_blue_q  <= in_blue;
      left_depth_q <= in_depth;
    end
  end

  pair_sum_t pair_sum;

  assign pair_sum.red   = PairW'(left_red_q) + PairW'(in_red);
  assign pair_sum.green = PairW'(left_green_q) + PairW'(in_green);
  assign pair_sum.blue  = PairW'(left_blue_q) + PairW'(in_blue);

  // ---------------------------------------------------------------------------
  // Upper row store: written on even rows, read on odd rows
  // ---------------------------------------------------------------------------
  row_entry_t       store_mem [StoreDepth];
  row_entry_t       rd_entry_q;
  row_entry_t       wr_entry;
  logic [SlotW-1:0] slot;
  logic             mem_we;
  logic             mem_re;

  assign slot   = col_q[ColW-1:1];
  assign mem_we = s_accept && col_q[0] && !row_q[0];
  assign mem_re = s_accept && col_q[0] && row_q[0];

  assign wr_entry.depth = left_depth_q;
  assign wr_entry.blue  = pair_sum.blue;
  assign wr_entry.green = pair_sum.green;
  assign wr_entry.red   = pair_sum.red;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[slot] <= wr_entry;
    end
    if (mem_re) begin
      rd_entry_q <= store_mem[slot];
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage: lower pair sums wait beside the store read
  // ---------------------------------------------------------------------------
  pair_sum_t s1_pair_q;
  logic      s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_pair_q <= pair_sum;
      s1_last_q <= frame_end_hit;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: add the two rows, round, present
  // ---------------------------------------------------------------------------
  logic [QuadW-1:0]  quad_red, quad_green, quad_blue;
  logic [ChanW-1:0]  out_red_q, out_green_q, out_blue_q;
  logic [DepthW-1:0] out_depth_q;
  logic              out_last_q;

  assign quad_red   = QuadW'(rd_entry_q.red) + QuadW'(s1_pair_q.red);
  assign quad_green = QuadW'(rd_entry_q.green) + QuadW'(s1_pair_q.green);
  assign quad_blue  = QuadW'(rd_entry_q.blue) + QuadW'(s1_pair_q.blue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_red_q   <= mean4(quad_red);
      out_green_q <= mean4(quad_green);
      out_blue_q  <= mean4(quad_blue);
      out_depth_q <= rd_entry_q.depth;
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_depth_q, out_blue_q, out_green_q, out_red_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RPLD_ASSERT_NEVER(a_store_port_clash, clk_i, rst_ni, mem_we && mem_re,
                     "row store read and written in one cycle")
  `RPLD_ASSERT(a_read_odd_position, clk_i, rst_ni,
               mem_re |-> (row_q[0] && col_q[0]),
               "row store read off an odd row and odd column")
  `RPLD_ASSERT(a_full_pipe_holds_input, clk_i, rst_ni,
               (s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_accept,
               "input request taken while both stages are stalled")
  `RPLD_ASSERT(a_result_follows_read, clk_i, rst_ni,
               (s1_adv && mem_re) |=> s1_valid_q,
               "store read did not load the read stage")

endmodule
